// File: rtl/core/marching_cubes_cell_triangulator_assert.svh
// Assertion macros for the cell triangulator checker.
`ifndef MARCHING_CUBES_CELL_TRIANGULATOR_ASSERT_SVH
`define MARCHING_CUBES_CELL_TRIANGULATOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define MCT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define MCT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mct_pkg.sv
// Shared types, constants and the triangle table of the cell triangulator.
package mct_pkg;

  localparam int NumCorners     = 8;
  localparam int NumEdges       = 12;
  localparam int SampleW        = 16;
  localparam int CellW          = 6;
  localparam int PosW           = 15;
  localparam int FracW          = 9;
  localparam int DenW           = 16;
  localparam int DivW           = 25;
  localparam int DivSteps       = 9;
  localparam int FracShift      = 8;
  localparam int GridDimDefault = 64;
  localparam int RowW           = 60;

  // Marker for an unused slot in a triangle row
  localparam logic [3:0] EdgeNone = 4'hf;

  // Corner offsets, bit n belongs to corner n
  localparam logic [NumCorners-1:0] CORNER_X = 8'b0110_0110;
  localparam logic [NumCorners-1:0] CORNER_Y = 8'b1111_0000;
  localparam logic [NumCorners-1:0] CORNER_Z = 8'b1100_1100;

  // End corners of each cube edge
  localparam logic [2:0] EDGE_FROM [NumEdges] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
                                                  3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3};
  localparam logic [2:0] EDGE_TO [NumEdges] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6,
                                                3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7};

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [FracW-1:0] frac_t;

  typedef struct packed {
    logic [CellW-1:0] x;
    logic [CellW-1:0] y;
    logic [CellW-1:0] z;
  } cell_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
  } vert_t;

  // Sideband that travels with a cell down the pipeline
  typedef struct packed {
    logic [NumCorners-1:0] cidx;
    cell_t                 loc;
  } side_t;

  // One divider lane: partial remainder, divisor, quotient so far
  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [DenW-1:0] den;
    frac_t           q;
  } div_lane_t;

  // Triangle table: edge digits, first digit in the top nibble, padded with EdgeNone
  function automatic logic [RowW-1:0] tri_row(input logic [NumCorners-1:0] idx);
    logic [RowW-1:0] r;
    case (idx)
      8'd1: r = 60'h083ffffffffffff;
      8'd2: r = 60'h019ffffffffffff;
      8'd3: r = 60'h183981fffffffff;
      8'd4: r = 60'h12affffffffffff;
      8'd5: r = 60'h08312afffffffff;
      8'd6: r = 60'h92a029fffffffff;
      8'd7: r = 60'h2832a8a98ffffff;
      8'd8: r = 60'h3b2ffffffffffff;
      8'd9: r = 60'h0b28b0fffffffff;
      8'd10: r = 60'h19023bfffffffff;
      8'd11: r = 60'h1b219b98bffffff;
      8'd12: r = 60'h3a1ba3fffffffff;
      8'd13: r = 60'h0a108a8baffffff;
      8'd14: r = 60'h3903b9ba9ffffff;
      8'd15: r = 60'h98aa8bfffffffff;
      8'd16: r = 60'h478ffffffffffff;
      8'd17: r = 60'h430734fffffffff;
      8'd18: r = 60'h019847fffffffff;
      8'd19: r = 60'h419471731ffffff;
      8'd20: r = 60'h12a847fffffffff;
      8'd21: r = 60'h34730412affffff;
      8'd22: r = 60'h92a902847ffffff;
      8'd23: r = 60'h2a9297273794fff;
      8'd24: r = 60'h8473b2fffffffff;
      8'd25: r = 60'hb47b24204ffffff;
      8'd26: r = 60'h90184723bffffff;
      8'd27: r = 60'h47b94b9b2921fff;
      8'd28: r = 60'h3a13ba784ffffff;
      8'd29: r = 60'h1ba14b1047b4fff;
      8'd30: r = 60'h47890b9bab03fff;
      8'd31: r = 60'h47b4b99baffffff;
      8'd32: r = 60'h954ffffffffffff;
      8'd33: r = 60'h954083fffffffff;
      8'd34: r = 60'h054150fffffffff;
      8'd35: r = 60'h854835315ffffff;
      8'd36: r = 60'h12a954fffffffff;
      8'd37: r = 60'h30812a495ffffff;
      8'd38: r = 60'h52a542402ffffff;
      8'd39: r = 60'h2a5325354348fff;
      8'd40: r = 60'h95423bfffffffff;
      8'd41: r = 60'h0b208b495ffffff;
      8'd42: r = 60'h05401523bffffff;
      8'd43: r = 60'h21525828b485fff;
      8'd44: r = 60'ha3ba13954ffffff;
      8'd45: r = 60'h4950818a18bafff;
      8'd46: r = 60'h54050b5bab03fff;
      8'd47: r = 60'h54858aa8bffffff;
      8'd48: r = 60'h978579fffffffff;
      8'd49: r = 60'h930953573ffffff;
      8'd50: r = 60'h078017157ffffff;
      8'd51: r = 60'h153357fffffffff;
      8'd52: r = 60'h978957a12ffffff;
      8'd53: r = 60'ha12950530573fff;
      8'd54: r = 60'h802825857a52fff;
      8'd55: r = 60'h2a5253357ffffff;
      8'd56: r = 60'h7957893b2ffffff;
      8'd57: r = 60'h95797292027bfff;
      8'd58: r = 60'h23b018178157fff;
      8'd59: r = 60'hb21b17715ffffff;
      8'd60: r = 60'h958857a13a3bfff;
      8'd61: r = 60'h5705097b010aba0;
      8'd62: r = 60'hba0b03a50807570;
      8'd63: r = 60'hba57b5fffffffff;
      8'd64: r = 60'ha65ffffffffffff;
      8'd65: r = 60'h0835a6fffffffff;
      8'd66: r = 60'h9015a6fffffffff;
      8'd67: r = 60'h1831985a6ffffff;
      8'd68: r = 60'h165261fffffffff;
      8'd69: r = 60'h165126308ffffff;
      8'd70: r = 60'h965906026ffffff;
      8'd71: r = 60'h598582526328fff;
      8'd72: r = 60'h23ba65fffffffff;
      8'd73: r = 60'hb08b20a65ffffff;
      8'd74: r = 60'h01923b5a6ffffff;
      8'd75: r = 60'h5a61929b298bfff;
      8'd76: r = 60'h63b653513ffffff;
      8'd77: r = 60'h08b0b50515b6fff;
      8'd78: r = 60'h3b6036065059fff;
      8'd79: r = 60'h65969bb98ffffff;
      8'd80: r = 60'h5a6478fffffffff;
      8'd81: r = 60'h43047365affffff;
      8'd82: r = 60'h1905a6847ffffff;
      8'd83: r = 60'ha65197173794fff;
      8'd84: r = 60'h612651478ffffff;
      8'd85: r = 60'h125526304347fff;
      8'd86: r = 60'h847905065026fff;
      8'd87: r = 60'h739794329596269;
      8'd88: r = 60'h3b2784a65ffffff;
      8'd89: r = 60'h5a647242027bfff;
      8'd90: r = 60'h01947823b5a6fff;
      8'd91: r = 60'h9219b294b7b45a6;
      8'd92: r = 60'h8473b53515b6fff;
      8'd93: r = 60'h51b5b610b7b404b;
      8'd94: r = 60'h059065036b63847;
      8'd95: r = 60'h65969b4797b9fff;
      8'd96: r = 60'ha4964afffffffff;
      8'd97: r = 60'h4a649a083ffffff;
      8'd98: r = 60'ha01a60640ffffff;
      8'd99: r = 60'h83181686461afff;
      8'd100: r = 60'h149124264ffffff;
      8'd101: r = 60'h308129249264fff;
      8'd102: r = 60'h024426fffffffff;
      8'd103: r = 60'h832824426ffffff;
      8'd104: r = 60'ha49a64b23ffffff;
      8'd105: r = 60'h08228b49a4a6fff;
      8'd106: r = 60'h3b201606461afff;
      8'd107: r = 60'h64161a48121b8b1;
      8'd108: r = 60'h964936913b63fff;
      8'd109: r = 60'h8b1810b61914641;
      8'd110: r = 60'h3b6360064ffffff;
      8'd111: r = 60'h648b68fffffffff;
      8'd112: r = 60'h7a678a89affffff;
      8'd113: r = 60'h0730a709a67afff;
      8'd114: r = 60'ha671a7178180fff;
      8'd115: r = 60'ha67a71173ffffff;
      8'd116: r = 60'h126168189867fff;
      8'd117: r = 60'h269291679093739;
      8'd118: r = 60'h780706602ffffff;
      8'd119: r = 60'h732672fffffffff;
      8'd120: r = 60'h23ba68a89867fff;
      8'd121: r = 60'h20727b09767a9a7;
      8'd122: r = 60'h1801781a767a23b;
      8'd123: r = 60'hb21b17a61671fff;
      8'd124: r = 60'h896867916b63136;
      8'd125: r = 60'h091b67fffffffff;
      8'd126: r = 60'h7807063b0b60fff;
      8'd127: r = 60'h7b6ffffffffffff;
      8'd128: r = 60'h76bffffffffffff;
      8'd129: r = 60'h308b76fffffffff;
      8'd130: r = 60'h019b76fffffffff;
      8'd131: r = 60'h819831b76ffffff;
      8'd132: r = 60'ha126b7fffffffff;
      8'd133: r = 60'h12a3086b7ffffff;
      8'd134: r = 60'h2902a96b7ffffff;
      8'd135: r = 60'h6b72a3a83a98fff;
      8'd136: r = 60'h723627fffffffff;
      8'd137: r = 60'h708760620ffffff;
      8'd138: r = 60'h276237019ffffff;
      8'd139: r = 60'h162186198876fff;
      8'd140: r = 60'ha76a17137ffffff;
      8'd141: r = 60'ha7617a187108fff;
      8'd142: r = 60'h03707a0a96a7fff;
      8'd143: r = 60'h76a7a88a9ffffff;
      8'd144: r = 60'h684b86fffffffff;
      8'd145: r = 60'h36b306046ffffff;
      8'd146: r = 60'h86b846901ffffff;
      8'd147: r = 60'h946963931b36fff;
      8'd148: r = 60'h6846b82a1ffffff;
      8'd149: r = 60'h12a30b06b046fff;
      8'd150: r = 60'h4b846b0292a9fff;
      8'd151: r = 60'ha93a32943b36463;
      8'd152: r = 60'h823842462ffffff;
      8'd153: r = 60'h042462fffffffff;
      8'd154: r = 60'h190234246438fff;
      8'd155: r = 60'h194142246ffffff;
      8'd156: r = 60'h8138618466a1fff;
      8'd157: r = 60'ha10a06604ffffff;
      8'd158: r = 60'h4634386a3039a93;
      8'd159: r = 60'ha946a4fffffffff;
      8'd160: r = 60'h49576bfffffffff;
      8'd161: r = 60'h083495b76ffffff;
      8'd162: r = 60'h50154076bffffff;
      8'd163: r = 60'hb76834354315fff;
      8'd164: r = 60'h954a1276bffffff;
      8'd165: r = 60'h6b712a083495fff;
      8'd166: r = 60'h76b54a42a402fff;
      8'd167: r = 60'h348354325a52b76;
      8'd168: r = 60'h723762549ffffff;
      8'd169: r = 60'h954086062687fff;
      8'd170: r = 60'h362376150540fff;
      8'd171: r = 60'h628687218485158;
      8'd172: r = 60'h954a16176137fff;
      8'd173: r = 60'h16a176107870954;
      8'd174: r = 60'h40a4a503a6a737a;
      8'd175: r = 60'h76a7a854a48afff;
      8'd176: r = 60'h6956b9b89ffffff;
      8'd177: r = 60'h36b063056095fff;
      8'd178: r = 60'h0b805b01556bfff;
      8'd179: r = 60'h6b3635531ffffff;
      8'd180: r = 60'h12a95b9b8b56fff;
      8'd181: r = 60'h0b306b09656912a;
      8'd182: r = 60'hb85b56805a52025;
      8'd183: r = 60'h6b36352a3a53fff;
      8'd184: r = 60'h589528562382fff;
      8'd185: r = 60'h956960062ffffff;
      8'd186: r = 60'h158180568382628;
      8'd187: r = 60'h156216fffffffff;
      8'd188: r = 60'h13616a386569896;
      8'd189: r = 60'ha10a06950560fff;
      8'd190: r = 60'h03856afffffffff;
      8'd191: r = 60'ha56ffffffffffff;
      8'd192: r = 60'hb5a75bfffffffff;
      8'd193: r = 60'hb5ab75830ffffff;
      8'd194: r = 60'h5b75ab190ffffff;
      8'd195: r = 60'ha75ab7981831fff;
      8'd196: r = 60'hb12b71751ffffff;
      8'd197: r = 60'h08312717572bfff;
      8'd198: r = 60'h9759279022b7fff;
      8'd199: r = 60'h75272b592328982;
      8'd200: r = 60'h25a235375ffffff;
      8'd201: r = 60'h820852875a25fff;
      8'd202: r = 60'h9015a35373a2fff;
      8'd203: r = 60'h982921872a25752;
      8'd204: r = 60'h135375fffffffff;
      8'd205: r = 60'h087071175ffffff;
      8'd206: r = 60'h903935537ffffff;
      8'd207: r = 60'h987597fffffffff;
      8'd208: r = 60'h5845a8ab8ffffff;
      8'd209: r = 60'h5045b05abb30fff;
      8'd210: r = 60'h01984a8aba45fff;
      8'd211: r = 60'hab4a45b34941314;
      8'd212: r = 60'h2512852b8458fff;
      8'd213: r = 60'h04b0b345b2b151b;
      8'd214: r = 60'h0250592b5458b85;
      8'd215: r = 60'h9452b3fffffffff;
      8'd216: r = 60'h25a352345384fff;
      8'd217: r = 60'h5a2524420ffffff;
      8'd218: r = 60'h3a235a385458019;
      8'd219: r = 60'h5a2524192942fff;
      8'd220: r = 60'h845853351ffffff;
      8'd221: r = 60'h045105fffffffff;
      8'd222: r = 60'h845853905035fff;
      8'd223: r = 60'h945ffffffffffff;
      8'd224: r = 60'h4b749b9abffffff;
      8'd225: r = 60'h0834979b79abfff;
      8'd226: r = 60'h1ab1b414074bfff;
      8'd227: r = 60'h3143481a474bab4;
      8'd228: r = 60'h4b79b492b912fff;
      8'd229: r = 60'h9749b791b2b1083;
      8'd230: r = 60'hb74b42240ffffff;
      8'd231: r = 60'hb74b42834324fff;
      8'd232: r = 60'h29a279237749fff;
      8'd233: r = 60'h9a7974a27870207;
      8'd234: r = 60'h37a3a274a1a040a;
      8'd235: r = 60'h1a2874fffffffff;
      8'd236: r = 60'h491417713ffffff;
      8'd237: r = 60'h491417081871fff;
      8'd238: r = 60'h403743fffffffff;
      8'd239: r = 60'h487ffffffffffff;
      8'd240: r = 60'h9a8ab8fffffffff;
      8'd241: r = 60'h30939bb9affffff;
      8'd242: r = 60'h01a0a88abffffff;
      8'd243: r = 60'h31ab3afffffffff;
      8'd244: r = 60'h12b1b99b8ffffff;
      8'd245: r = 60'h30939b1292b9fff;
      8'd246: r = 60'h02b80bfffffffff;
      8'd247: r = 60'h32bffffffffffff;
      8'd248: r = 60'h23828aa89ffffff;
      8'd249: r = 60'h9a2092fffffffff;
      8'd250: r = 60'h23828a0181a8fff;
      8'd251: r = 60'h1a2ffffffffffff;
      8'd252: r = 60'h138918fffffffff;
      8'd253: r = 60'h091ffffffffffff;
      8'd254: r = 60'h038ffffffffffff;
      default: r = '1;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/marching_cubes_cell_triangulator.sv
// Top level of the marching cubes cell triangulator.
// Takes one grid cell per transfer and returns its triangles, one per transfer, vertices
// in grid units with 8 fraction bits, the final triangle of a cell flagged by last_triangle.
// A cell runs through a 12-stage pipeline (two stages of edge setup, nine divider stages
// with one quotient bit each, one position stage) into the triangle emitter, which drives
// the single result port, holds a cell until its last triangle leaves and drops empty cases.
// While the emitter is busy and a cell waits at the pipeline tail, the pipeline holds and
// cell_stall is high. Write iso_level through cfg_we/cfg_data only while the block is idle;
// the block itself does not enforce this.
module marching_cubes_cell_triangulator #(
  parameter int GRID_DIM = mct_pkg::GridDimDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mct_pkg::SampleW-1:0]     cfg_data,
  input  logic                            cell_valid,
  output logic                            cell_stall,
  input  logic [mct_pkg::CellW-1:0]       cell_x,
  input  logic [mct_pkg::CellW-1:0]       cell_y,
  input  logic [mct_pkg::CellW-1:0]       cell_z,
  input  logic signed [mct_pkg::SampleW-1:0] corner_0,
  input  logic signed [mct_pkg::SampleW-1:0] corner_1,
  input  logic signed [mct_pkg::SampleW-1:0] corner_2,
  input  logic signed [mct_pkg::SampleW-1:0] corner_3,
  input  logic signed [mct_pkg::SampleW-1:0] corner_4,
  input  logic signed [mct_pkg::SampleW-1:0] corner_5,
  input  logic signed [mct_pkg::SampleW-1:0] corner_6,
  input  logic signed [mct_pkg::SampleW-1:0] corner_7,
  output logic                            tri_valid,
  input  logic                            tri_stall,
  output logic [mct_pkg::PosW-1:0]        first_x,
  output logic [mct_pkg::PosW-1:0]        first_y,
  output logic [mct_pkg::PosW-1:0]        first_z,
  output logic [mct_pkg::PosW-1:0]        second_x,
  output logic [mct_pkg::PosW-1:0]        second_y,
  output logic [mct_pkg::PosW-1:0]        second_z,
  output logic [mct_pkg::PosW-1:0]        third_x,
  output logic [mct_pkg::PosW-1:0]        third_y,
  output logic [mct_pkg::PosW-1:0]        third_z,
  output logic                            last_triangle
);
  import mct_pkg::*;

  sample_t               iso_level;
  sample_t               corner [NumCorners];
  cell_t                 cell_idx;
  logic                  adv;
  logic                  take;
  logic                  prep_valid;
  side_t                 prep_side;
  div_lane_t             prep_lane [NumEdges];
  logic                  div_valid;
  side_t                 div_side;
  frac_t                 div_frac [NumEdges];
  logic                  pos_valid;
  logic [NumCorners-1:0] pos_cidx;
  vert_t                 pos_vert [NumEdges];
  vert_t                 first_v;
  vert_t                 second_v;
  vert_t                 third_v;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      iso_level <= '0;
    end else if (cfg_we) begin
      iso_level <= cfg_data;
    end
  end

  assign corner   = '{corner_0, corner_1, corner_2, corner_3,
                      corner_4, corner_5, corner_6, corner_7};
  assign cell_idx = '{x: cell_x, y: cell_y, z: cell_z};

  // Move the whole pipeline when its tail is empty or the emitter takes it
  assign adv        = !pos_valid || take;
  assign cell_stall = !adv;

  mct_edge_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (cell_valid),
    .in_cell   (cell_idx),
    .in_corner (corner),
    .iso       (iso_level),
    .out_valid (prep_valid),
    .out_side  (prep_side),
    .out_lane  (prep_lane)
  );

  mct_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (prep_valid),
    .in_side   (prep_side),
    .in_lane   (prep_lane),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_frac  (div_frac)
  );

  mct_edge_pos #(
    .GRID_DIM (GRID_DIM)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (div_valid),
    .in_side   (div_side),
    .in_frac   (div_frac),
    .out_valid (pos_valid),
    .out_cidx  (pos_cidx),
    .out_vert  (pos_vert)
  );

  mct_tri_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pos_valid),
    .in_cidx   (pos_cidx),
    .in_vert   (pos_vert),
    .take      (take),
    .tri_stall (tri_stall),
    .tri_valid (tri_valid),
    .first     (first_v),
    .second    (second_v),
    .third     (third_v),
    .last      (last_triangle)
  );

  assign first_x  = first_v.x;
  assign first_y  = first_v.y;
  assign first_z  = first_v.z;
  assign second_x = second_v.x;
  assign second_y = second_v.y;
  assign second_z = second_v.z;
  assign third_x  = third_v.x;
  assign third_y  = third_v.y;
  assign third_z  = third_v.z;

endmodule

// File: rtl/core/mct_edge_prep.sv
// Front end: case index, per-edge numerator and divisor for the interpolation divide.
module mct_edge_prep (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  mct_pkg::cell_t         in_cell,
  input  mct_pkg::sample_t       in_corner [mct_pkg::NumCorners],
  input  mct_pkg::sample_t       iso,
  output logic                   out_valid,
  output mct_pkg::side_t         out_side,
  output mct_pkg::div_lane_t     out_lane [mct_pkg::NumEdges]
);
  import mct_pkg::*;

  // Orient the edge so the divisor is positive, clamp, and form num*256 + den/2
  function automatic div_lane_t edge_lane(input logic signed [SampleW:0] num,
                                          input logic signed [SampleW:0] den);
    logic signed [SampleW+1:0] n;
    logic signed [SampleW+1:0] d;
    div_lane_t l;
    n = {num[SampleW], num};
    d = {den[SampleW], den};
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (n < 0) begin
      n = '0;
    end else if (n > d) begin
      n = d;
    end
    l.q   = '0;
    l.den = d[DenW-1:0];
    l.rem = {1'b0, n[DenW-1:0], {FracShift{1'b0}}} + DivW'(d[DenW-1:1]);
    // Equal end samples: quotient comes out zero
    if (d == 0) begin
      l.den = DenW'(1);
      l.rem = '0;
    end
    return l;
  endfunction

  logic                        vld_a;
  side_t                       side_a;
  logic signed [SampleW:0]     num_a [NumCorners];
  logic signed [SampleW:0]     den_a [NumEdges];
  logic [NumCorners-1:0]       cidx;

  // Classify corners against the threshold
  always_comb begin
    for (int n = 0; n < NumCorners; n++) begin
      cidx[n] = (in_corner[n] <= iso);
    end
  end

  // Stage A: differences
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (adv) begin
      vld_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_a.cidx <= cidx;
      side_a.loc  <= in_cell;
      for (int n = 0; n < NumCorners; n++) begin
        num_a[n] <= {iso[SampleW-1], iso} - {in_corner[n][SampleW-1], in_corner[n]};
      end
      for (int e = 0; e < NumEdges; e++) begin
        den_a[e] <= {in_corner[EDGE_TO[e]][SampleW-1], in_corner[EDGE_TO[e]]}
                  - {in_corner[EDGE_FROM[e]][SampleW-1], in_corner[EDGE_FROM[e]]};
      end
    end
  end

  // Stage B: divider operands
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side <= side_a;
      for (int e = 0; e < NumEdges; e++) begin
        out_lane[e] <= edge_lane(num_a[EDGE_FROM[e]], den_a[e]);
      end
    end
  end

endmodule

// File: rtl/core/mct_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, one lane per cube edge.
module mct_div_pipe (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  mct_pkg::side_t         in_side,
  input  mct_pkg::div_lane_t     in_lane [mct_pkg::NumEdges],
  output logic                   out_valid,
  output mct_pkg::side_t         out_side,
  output mct_pkg::frac_t         out_frac [mct_pkg::NumEdges]
);
  import mct_pkg::*;

  // Try the divisor at weight 2^sh and keep the difference if it fits
  function automatic div_lane_t div_step(input div_lane_t l, input int unsigned sh);
    logic [DivW-1:0] trial;
    div_lane_t r;
    trial = DivW'(l.den) << sh;
    r = l;
    if (l.rem >= trial) begin
      r.rem = l.rem - trial;
      r.q   = l.q | (FracW'(1) << sh);
    end
    return r;
  endfunction

  logic      vld   [DivSteps];
  side_t     side  [DivSteps];
  div_lane_t lane  [DivSteps][NumEdges];

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    localparam int unsigned Sh = DivSteps - 1 - s;
    logic      src_vld;
    side_t     src_side;
    div_lane_t src_lane [NumEdges];

    if (s == 0) begin : g_head
      assign src_vld  = in_valid;
      assign src_side = in_side;
      assign src_lane = in_lane;
    end else begin : g_body
      assign src_vld  = vld[s-1];
      assign src_side = side[s-1];
      assign src_lane = lane[s-1];
    end

    // Advance valid with the data
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[s] <= src_side;
        for (int e = 0; e < NumEdges; e++) begin
          lane[s][e] <= div_step(src_lane[e], Sh);
        end
      end
    end
  end

  assign out_valid = vld[DivSteps-1];
  assign out_side  = side[DivSteps-1];

  always_comb begin
    for (int e = 0; e < NumEdges; e++) begin
      out_frac[e] = lane[DivSteps-1][e].q;
    end
  end

endmodule

// File: rtl/core/mct_edge_pos.sv
// Per-edge vertex position from cell index and fraction, saturated to the grid.
module mct_edge_pos #(
  parameter int GRID_DIM = mct_pkg::GridDimDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  mct_pkg::side_t         in_side,
  input  mct_pkg::frac_t         in_frac [mct_pkg::NumEdges],
  output logic                   out_valid,
  output logic [mct_pkg::NumCorners-1:0] out_cidx,
  output mct_pkg::vert_t         out_vert [mct_pkg::NumEdges]
);
  import mct_pkg::*;

  localparam int FullScale = GRID_DIM * (1 << FracShift);
  localparam int PosMax    = (FullScale > 32767) ? 32767 : FullScale;
  localparam logic [PosW:0] PosTop = (PosW + 1)'(PosMax);

  // Move from the first corner toward the second by frac along one axis
  function automatic pos_t axis_pos(input logic [CellW-1:0] c, input logic oa,
                                    input logic ob, input frac_t f);
    logic [PosW:0] p;
    p = ((PosW + 1)'(c) + (PosW + 1)'(oa)) << FracShift;
    if (ob && !oa) begin
      p = p + (PosW + 1)'(f);
    end else if (oa && !ob) begin
      p = p - (PosW + 1)'(f);
    end
    if (p > PosTop) begin
      p = PosTop;
    end
    return p[PosW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cidx <= in_side.cidx;
      for (int e = 0; e < NumEdges; e++) begin
        out_vert[e].x <= axis_pos(in_side.loc.x, CORNER_X[EDGE_FROM[e]],
                                  CORNER_X[EDGE_TO[e]], in_frac[e]);
        out_vert[e].y <= axis_pos(in_side.loc.y, CORNER_Y[EDGE_FROM[e]],
                                  CORNER_Y[EDGE_TO[e]], in_frac[e]);
        out_vert[e].z <= axis_pos(in_side.loc.z, CORNER_Z[EDGE_FROM[e]],
                                  CORNER_Z[EDGE_TO[e]], in_frac[e]);
      end
    end
  end

endmodule

// File: rtl/core/mct_tri_emit.sv
// Triangle emitter: walks the table row of one cell and drives the result register.
module mct_tri_emit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [mct_pkg::NumCorners-1:0] in_cidx,
  input  mct_pkg::vert_t         in_vert [mct_pkg::NumEdges],
  output logic                   take,
  input  logic                   tri_stall,
  output logic                   tri_valid,
  output mct_pkg::vert_t         first,
  output mct_pkg::vert_t         second,
  output mct_pkg::vert_t         third,
  output logic                   last
);
  import mct_pkg::*;

  // Select the vertex of one edge
  function automatic vert_t pick(input vert_t v [NumEdges], input logic [3:0] d);
    vert_t r;
    r = '0;
    for (int e = 0; e < NumEdges; e++) begin
      if (d == 4'(e)) begin
        r = v[e];
      end
    end
    return r;
  endfunction

  logic            em_valid;
  logic [RowW-1:0] em_row;
  vert_t           em_vert [NumEdges];
  logic [RowW-1:0] in_row;
  logic            out_free;
  logic            emit;
  logic            em_last;

  always_comb begin
    in_row   = tri_row(in_cidx);
    out_free = !tri_valid || !tri_stall;
    emit     = em_valid && out_free;
    em_last  = (em_row[RowW-13 -: 4] == EdgeNone);
    take     = !em_valid || (emit && em_last);
  end

  // Hold a cell until its last triangle leaves; drop empty cases
  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid  <= 1'b0;
      tri_valid <= 1'b0;
    end else begin
      if (take) begin
        em_valid <= in_valid && (in_row[RowW-1 -: 4] != EdgeNone);
      end
      if (emit) begin
        tri_valid <= 1'b1;
      end else if (!tri_stall) begin
        tri_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      em_row  <= in_row;
      em_vert <= in_vert;
    end else if (emit) begin
      em_row <= {em_row[RowW-13:0], {3{EdgeNone}}};
    end
  end

  // Load the result register, vertex order reversed against the table
  always_ff @(posedge clk) begin
    if (emit) begin
      first  <= pick(em_vert, em_row[RowW-9 -: 4]);
      second <= pick(em_vert, em_row[RowW-5 -: 4]);
      third  <= pick(em_vert, em_row[RowW-1 -: 4]);
      last   <= em_last;
    end
  end

endmodule

// File: rtl/core/mct_checker.sv
// Port-level checks of the cell triangulator, bound to the top level.
`include "marching_cubes_cell_triangulator_assert.svh"

module mct_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cell_stall,
  input logic                            tri_valid,
  input logic                            tri_stall,
  input logic [mct_pkg::PosW-1:0]        first_x,
  input logic [mct_pkg::PosW-1:0]        second_y,
  input logic [mct_pkg::PosW-1:0]        third_z,
  input logic                            last_triangle
);

  // A stalled triangle holds
  `MCT_ASSERT_NEXT(a_tri_hold, clk, rst, tri_valid && tri_stall, tri_valid && $stable(first_x) && $stable(second_y) && $stable(third_z) && $stable(last_triangle), "stalled triangle changed")

  // A cell's triangles leave back to back once the port is free
  `MCT_ASSERT_NEXT(a_tri_burst, clk, rst, tri_valid && !tri_stall && !last_triangle, tri_valid, "gap inside a cell's triangles")

  // Input backpressure only while the emitter has work for the result port
  `MCT_ASSERT_NEXT(a_stall_busy, clk, rst, cell_stall, tri_valid, "input stalled with no result pending")

endmodule

bind marching_cubes_cell_triangulator mct_checker u_mct_checker (.*);
